// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is asserted
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/trm_pkg.sv =====
// package for the tile reference matcher: fixed widths and reset values
// no dependencies
`default_nettype none

package trm_pkg;

  localparam int PIX_W    = 24;    // rgb pixel width
  localparam int TP_W     = 13;    // tile size register width
  localparam int TP_RESET = 4096;  // tile size after reset

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_MATCH = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

endpackage : trm_pkg

`default_nettype wire

// ===== src/trm_if.sv =====
// valid/ready channel interfaces for the tile reference matcher
// depends on trm_pkg
`default_nettype none

interface trm_in_if
  import trm_pkg::*;
  ();
  logic   valid;
  logic   ready;
  logic   mode;
  pixel_t pixel;
  logic   frame_start;

  modport source  (output valid, mode, pixel, frame_start, input ready);
  modport sink    (input valid, mode, pixel, frame_start, output ready);
  modport monitor (input valid, ready, mode, pixel, frame_start);
endinterface : trm_in_if

interface trm_out_if #(
  parameter int POS_W = 4
) ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] tile_code;
  logic             mismatch_error;
  logic             frame_done;

  modport source  (output valid, position, tile_code, mismatch_error, frame_done,
                   input ready);
  modport sink    (input valid, position, tile_code, mismatch_error, frame_done,
                   output ready);
  modport monitor (input valid, ready, position, tile_code, mismatch_error,
                   frame_done);
endinterface : trm_out_if

`default_nettype wire

// ===== src/tile_reference_matcher.sv =====
// a result passes the stage 1 registers and then the output register
// throughput: one pixel per cycle unless a result waits on a full output register;
// one read of every reference bank per pixel and one write per loaded pixel of a tile with a bank
// reset: synchronous, active low; clears counters and marks, sets the flags, tile size to 4096;
// the reference banks are not cleared and hold garbage until loaded
`default_nettype none

module tile_reference_matcher
  import trm_pkg::*;
#(
  parameter int GRID_SIDE       = 4,
  parameter int MAX_TILE_PIXELS = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  trm_in_if.sink               in_ch,
  trm_out_if.source            out_ch,
  input  wire logic            cfg_we,
  input  wire logic [TP_W-1:0] cfg_wdata
);

  localparam int NUM_TILES = GRID_SIDE * GRID_SIDE;
  localparam int NUM_REFS  = NUM_TILES - 1;
  localparam int TC_W      = $clog2(NUM_TILES);
  localparam int PC_W      = $clog2(MAX_TILE_PIXELS);
  localparam int SZ_W      = (TP_W > PC_W + 1) ? TP_W : PC_W + 1;

  // ---------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------
  logic [TP_W-1:0] tile_px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_px_r <= TP_W'(TP_RESET);
    end else if (cfg_we) begin
      tile_px_r <= cfg_wdata;
    end
  end

  // effective tile size: zero acts as one, clamp at the bank depth
  logic [SZ_W-1:0] tile_size;
  logic [SZ_W-1:0] tp_ext;

  always_comb begin
    tp_ext = SZ_W'(tile_px_r);
    if (tp_ext == '0) begin
      tile_size = SZ_W'(1);
    end else if (tp_ext > SZ_W'(MAX_TILE_PIXELS)) begin
      tile_size = SZ_W'(MAX_TILE_PIXELS);
    end else begin
      tile_size = tp_ext;
    end
  end

  // ---------------------------------------------------------------
  // stage 0: pixel and tile counters, bank addressing
  // ---------------------------------------------------------------
  logic            in_acc;
  logic [PC_W-1:0] pix_cnt_r, pix_cnt_nxt, pix_cur;
  logic [TC_W-1:0] tile_cnt_r, tile_cnt_nxt, tile_cur;
  logic            tile_end, last_tile;

  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    // frame start restarts the counters before this pixel is taken
    pix_cur   = in_ch.frame_start ? '0 : pix_cnt_r;
    tile_cur  = in_ch.frame_start ? '0 : tile_cnt_r;
    tile_end  = (SZ_W'(pix_cur) + SZ_W'(1)) >= tile_size;
    last_tile = (tile_cur == TC_W'(NUM_TILES - 1));
    if (tile_end) begin
      pix_cnt_nxt  = '0;
      tile_cnt_nxt = last_tile ? '0 : tile_cur + TC_W'(1);
    end else begin
      pix_cnt_nxt  = pix_cur + PC_W'(1);
      tile_cnt_nxt = tile_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r  <= '0;
      tile_cnt_r <= '0;
    end else if (in_acc) begin
      pix_cnt_r  <= pix_cnt_nxt;
      tile_cnt_r <= tile_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------
  // reference banks: one per reference tile, all read at the same pixel
  // address, written only by the bank that owns the tile being loaded;
  // the blank tile has no bank so it is dropped.
  // a pixel's write lands at its accept edge, before any later read of
  // the same word, so no forwarding is needed
  // ---------------------------------------------------------------
  pixel_t rd_data_r [NUM_REFS];

  for (genvar b = 0; b < NUM_REFS; b++) begin : g_bank
    pixel_t bank_mem [MAX_TILE_PIXELS];
    logic   bank_we;

    assign bank_we = in_acc && (in_ch.mode == MODE_LOAD) && (tile_cur == TC_W'(b));

    always_ff @(posedge clk) begin
      if (bank_we) begin
        bank_mem[pix_cur] <= in_ch.pixel;
      end
      if (in_acc) begin
        rd_data_r[b] <= bank_mem[pix_cur];
      end
    end
  end

  // stage 1 holding registers
  logic            s1_v_r;
  logic            s1_mode_r;
  pixel_t          s1_pixel_r;
  logic            s1_start_r;
  logic            s1_end_r;
  logic            s1_last_r;
  logic [TC_W-1:0] s1_tile_r;

  // ---------------------------------------------------------------
  // stage 1: compare against all references, update flags and marks
  // ---------------------------------------------------------------
  logic [NUM_REFS-1:0] flags_r, flags_cur, flags_upd, mism;
  logic                blank_r, blank_cur;
  logic                err_r, err_cur;
  logic                produce, s1_adv, out_free;
  logic [TC_W-1:0]     code;
  logic                err_hit;

  always_comb begin
    // a frame start sets the flags and clears the marks first
    flags_cur = s1_start_r ? {NUM_REFS{1'b1}} : flags_r;
    blank_cur = s1_start_r ? 1'b0 : blank_r;
    err_cur   = s1_start_r ? 1'b0 : err_r;
    for (int b = 0; b < NUM_REFS; b++) begin
      mism[b] = (rd_data_r[b] != s1_pixel_r);
    end
    flags_upd = (s1_mode_r == MODE_MATCH) ? (flags_cur & ~mism) : flags_cur;
    // lowest matching reference wins
    code = '0;
    for (int b = NUM_REFS - 1; b >= 0; b--) begin
      if (flags_upd[b]) begin
        code = TC_W'(b + 1);
      end
    end
    err_hit = (flags_upd == '0) && blank_cur;
    produce = s1_end_r && (s1_mode_r == MODE_MATCH) && !err_cur;
  end

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign s1_adv      = s1_v_r && (!produce || out_free);
  assign in_ch.ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  // stage 1 payload loads with the bank read data, on accept only
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r  <= in_ch.mode;
      s1_pixel_r <= in_ch.pixel;
      s1_start_r <= in_ch.frame_start;
      s1_end_r   <= tile_end;
      s1_last_r  <= last_tile;
      s1_tile_r  <= tile_cur;
    end
  end

  logic [NUM_REFS-1:0] flags_nxt;
  logic                blank_nxt, err_nxt;

  always_comb begin
    flags_nxt = flags_upd;
    blank_nxt = blank_cur;
    err_nxt   = err_cur;
    if (s1_end_r) begin
      flags_nxt = {NUM_REFS{1'b1}};
      if (s1_last_r) begin
        // end of frame behaves like a frame start
        blank_nxt = 1'b0;
        err_nxt   = 1'b0;
      end else if (produce && (flags_upd == '0)) begin
        if (!blank_cur) begin
          blank_nxt = 1'b1;
        end else begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= {NUM_REFS{1'b1}};
      blank_r <= 1'b0;
      err_r   <= 1'b0;
    end else if (s1_adv) begin
      flags_r <= flags_nxt;
      blank_r <= blank_nxt;
      err_r   <= err_nxt;
    end
  end

  // ---------------------------------------------------------------
  // output register: decouples the result from the pixel pipeline
  // ---------------------------------------------------------------
  logic            out_v_r;
  logic [TC_W-1:0] out_pos_r, out_code_r;
  logic            out_err_r, out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && produce) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && produce) begin
      out_pos_r  <= s1_tile_r;
      out_code_r <= err_hit ? '0 : code;
      out_err_r  <= err_hit;
      out_done_r <= s1_last_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.position       = out_pos_r;
  assign out_ch.tile_code      = out_code_r;
  assign out_ch.mismatch_error = out_err_r;
  assign out_ch.frame_done     = out_done_r;

endmodule : tile_reference_matcher

`default_nettype wire

// ===== src/trm_checker.sv =====
// port-level checker for the tile reference matcher, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module trm_checker #(
  parameter int GRID_SIDE = 4
) (
  input wire logic                                     clk,
  input wire logic                                     rst_n,
  input wire logic                                     in_ready,
  input wire logic                                     out_valid,
  input wire logic                                     out_ready,
  input wire logic [$clog2(GRID_SIDE * GRID_SIDE)-1:0] out_pos,
  input wire logic [$clog2(GRID_SIDE * GRID_SIDE)-1:0] out_code,
  input wire logic                                     out_err,
  input wire logic                                     out_done
);

  localparam int NUM_TILES = GRID_SIDE * GRID_SIDE;
  localparam int TC_W      = $clog2(NUM_TILES);
  localparam logic [TC_W-1:0] LAST_POS = TC_W'(NUM_TILES - 1);

  `ASSERT_ALWAYS(a_out_idle_after_reset, clk, !rst_n |=> !out_valid, "result valid after reset")
  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_CLKD(a_err_code_zero, clk, rst_n, out_valid && out_err |-> out_code == '0, "error code")
  `ASSERT_CLKD(a_done_pos, clk, rst_n, out_valid && out_done |-> out_pos == LAST_POS, "done early")
  `ASSERT_CLKD(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled")

endmodule : trm_checker

bind tile_reference_matcher trm_checker #(
  .GRID_SIDE (GRID_SIDE)
) u_trm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pos   (out_ch.position),
  .out_code  (out_ch.tile_code),
  .out_err   (out_ch.mismatch_error),
  .out_done  (out_ch.frame_done)
);

`default_nettype wire
